[src/constant_power_stereo_mixer_top_macros.svh]
// Assertion macros for the constant-power stereo mixer.
// Used by constant_power_stereo_mixer_top; no other dependencies.
`ifndef CONSTANT_POWER_STEREO_MIXER_TOP_MACROS_SVH
`define CONSTANT_POWER_STEREO_MIXER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CPSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cpsm_pkg.sv]
// Shared types and constants for the constant-power stereo mixer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package cpsm_pkg;

   // Field widths
   localparam int GAIN_W = 16;
   localparam int PAN_W  = 17;
   localparam int OUT_W  = 24;

   // Pan law arithmetic
   localparam int ROOT_W     = 16;
   localparam int REM_W      = ROOT_W + 2;
   localparam int RAD_W      = 32;
   localparam int MIX_W      = 17;
   localparam int MIX_FRAC   = 14;
   localparam int PROD_SHIFT = 29;

   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int CNT_W      = $clog2(SQRT_STEPS);

   localparam logic signed [PAN_W-1:0] PAN_MAX = 17'sd32768;
   localparam logic signed [PAN_W-1:0] PAN_MIN = -17'sd32768;
   localparam logic [MIX_W-1:0]        MIX_ONE = 17'd65536;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_MUL_SG,
      ST_MUL_L,
      ST_MUL_R,
      ST_ACC_R,
      ST_EMIT
   } state_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MOP_NONE,
      MOP_SG,
      MOP_PAN_L,
      MOP_PAN_R
   } mul_op_type;

   // Accumulator update selection
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LEFT,
      ACC_RIGHT
   } acc_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       sqrt_step;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       emit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last;
      logic out_full;
   } status_type;

endpackage

`default_nettype wire

[src/constant_power_stereo_mixer_top.sv]
// Top level of the constant-power stereo mixer.
// Depends on cpsm_pkg, cpsm_ctrl, cpsm_datapath and the assertion macro header.
//
// Mixes a frame of mono channels to stereo with the square-root pan law.
// Each transaction on req_ is one channel; the transaction marked last
// produces one rsp_ transaction carrying both saturated 24-bit sums, after
// which the accumulators clear. One channel is handled at a time: after
// acceptance a channel runs the bit-serial square roots of both pan gains,
// one result bit per cycle, then three passes through the single shared
// multiplier and the accumulate, before it is ready again; the final channel
// of a frame also loads the result register. A result waiting in that
// register does not hold up the next channel, only the next frame's final
// channel.
`default_nettype none

module constant_power_stereo_mixer_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACC_WIDTH    = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic        [cpsm_pkg::GAIN_W-1:0] req_channel_gain,
   input  logic signed [cpsm_pkg::PAN_W-1:0]  req_pan_position,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cpsm_pkg::OUT_W-1:0]  rsp_left_sum,
   output logic signed [cpsm_pkg::OUT_W-1:0]  rsp_right_sum
);
   import cpsm_pkg::*;

`include "constant_power_stereo_mixer_top_macros.svh"

   cmd_type    cmd;
   status_type status;

   cpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpsm_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .req_channel_gain (req_channel_gain),
      .req_pan_position (req_pan_position),
      .req_last         (req_last),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_left_sum     (rsp_left_sum),
      .rsp_right_sum    (rsp_right_sum)
   );

   // Checks
   `CPSM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted a channel while busy")
   `CPSM_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit, !(rsp_valid && !rsp_ready), "result overwritten before taken")
   `CPSM_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid, "loaded result not presented")
   `CPSM_ASSERT_SAME(a_emit_when_last, clock, reset, cmd.emit, status.last, "result on a channel not marked last")

endmodule

`default_nettype wire

[src/cpsm_ctrl.sv]
// Controller state machine for the constant-power stereo mixer.
// Depends on cpsm_pkg; drives the datapath through cmd_type.
`default_nettype none

module cpsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  cpsm_pkg::status_type status,
   output cpsm_pkg::cmd_type    cmd
);
   import cpsm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sqrt_done;
   logic             out_free;

   assign sqrt_done = (cnt_ff == CNT_W'(SQRT_STEPS - 1));
   assign out_free  = !status.out_full || rsp_ready;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (sqrt_done) state_in = ST_MUL_SG;
         end
         ST_MUL_SG: state_in = ST_MUL_L;
         ST_MUL_L:  state_in = ST_MUL_R;
         ST_MUL_R:  state_in = ST_ACC_R;
         ST_ACC_R: begin
            state_in = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '{load: 1'b0, sqrt_step: 1'b0, mul_op: MOP_NONE,
                    acc_op: ACC_NONE, emit: 1'b0};
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQRT:   cmd.sqrt_step = 1'b1;
         ST_MUL_SG: cmd.mul_op = MOP_SG;
         ST_MUL_L:  cmd.mul_op = MOP_PAN_L;
         ST_MUL_R: begin
            // right product overlaps the left accumulate
            cmd.mul_op = MOP_PAN_R;
            cmd.acc_op = ACC_LEFT;
         end
         ST_ACC_R:  cmd.acc_op = ACC_RIGHT;
         ST_EMIT:   cmd.emit = out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[src/cpsm_datapath.sv]
// Datapath for the constant-power stereo mixer: pan clamp, two bit-serial
// square roots, shared multiplier, saturating accumulators, result register.
// Depends on cpsm_pkg; commanded by cpsm_ctrl.
`default_nettype none

module cpsm_datapath #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACC_WIDTH    = 40
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cpsm_pkg::cmd_type                       cmd,
   output cpsm_pkg::status_type                    status,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample,
   input  logic        [cpsm_pkg::GAIN_W-1:0]      req_channel_gain,
   input  logic signed [cpsm_pkg::PAN_W-1:0]       req_pan_position,
   input  logic                                    req_last,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic signed [cpsm_pkg::OUT_W-1:0]       rsp_left_sum,
   output logic signed [cpsm_pkg::OUT_W-1:0]       rsp_right_sum
);
   import cpsm_pkg::*;

   localparam int MA_W   = SAMPLE_WIDTH + GAIN_W + 1;
   localparam int MB_W   = ROOT_W + 1;
   localparam int PROD_W = MA_W + MB_W;
   localparam int TERM_W = PROD_W - PROD_SHIFT;
   localparam int SUM_W  = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;

   // One restoring square-root step: two radicand bits in, one root bit out
   function automatic logic [REM_W+ROOT_W-1:0] root_step(
      input logic [REM_W-1:0]  rem,
      input logic [ROOT_W-1:0] root,
      input logic [1:0]        pair
   );
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      cur   = {rem[REM_W-3:0], pair};
      trial = {root, 2'b01};
      if (cur >= trial) return {cur - trial, root[ROOT_W-2:0], 1'b1};
      else              return {cur, root[ROOT_W-2:0], 1'b0};
   endfunction

   // Saturate a wide sum to the accumulator range
   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [SUM_W-1:0] sum
   );
      logic [SUM_W-ACC_WIDTH:0] upper;
      upper = sum[SUM_W-1:ACC_WIDTH-1];
      if (&upper || ~|upper) return sum[ACC_WIDTH-1:0];
      else if (sum[SUM_W-1]) return {1'b1, {(ACC_WIDTH-1){1'b0}}};
      else                   return {1'b0, {(ACC_WIDTH-1){1'b1}}};
   endfunction

   // Saturate an accumulator to the output range
   function automatic logic signed [OUT_W-1:0] sat_out(
      input logic signed [ACC_WIDTH-1:0] acc
   );
      logic [ACC_WIDTH-OUT_W:0] upper;
      upper = acc[ACC_WIDTH-1:OUT_W-1];
      if (&upper || ~|upper) return acc[OUT_W-1:0];
      else if (acc[ACC_WIDTH-1]) return {1'b1, {(OUT_W-1){1'b0}}};
      else                       return {1'b0, {(OUT_W-1){1'b1}}};
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [GAIN_W-1:0]              gain_ff;
   logic                           last_ff;
   logic [RAD_W-1:0]               rad_l_ff, rad_r_ff;
   logic [REM_W-1:0]               rem_l_ff, rem_r_ff;
   logic [ROOT_W-1:0]              root_l_ff, root_r_ff;
   logic signed [MA_W-1:0]         sg_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [ACC_WIDTH-1:0]    left_acc_ff, right_acc_ff;
   logic                           rsp_valid_ff;
   logic signed [OUT_W-1:0]        left_sum_ff, right_sum_ff;

   logic [MIX_W-1:0]               mix, lmix;
   logic [REM_W+ROOT_W-1:0]        step_l, step_r;
   logic signed [MA_W-1:0]         mul_a;
   logic signed [MB_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]       product;
   logic signed [TERM_W-1:0]       term;
   logic signed [ACC_WIDTH-1:0]    acc_sel;
   logic signed [SUM_W-1:0]        sum;
   logic signed [ACC_WIDTH-1:0]    acc_new;

   // Pan clamp and mix position
   always_comb begin
      if (req_pan_position < PAN_MIN)      mix = '0;
      else if (req_pan_position > PAN_MAX) mix = MIX_ONE;
      else mix = MIX_W'(req_pan_position + PAN_MAX);
      lmix = MIX_ONE - mix;
   end

   assign step_l = root_step(rem_l_ff, root_l_ff, rad_l_ff[RAD_W-1:RAD_W-2]);
   assign step_r = root_step(rem_r_ff, root_r_ff, rad_r_ff[RAD_W-1:RAD_W-2]);

   // Input latch and square-root iteration
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         gain_ff   <= req_channel_gain;
         last_ff   <= req_last;
         rad_l_ff  <= {1'b0, lmix, {MIX_FRAC{1'b0}}};
         rad_r_ff  <= {1'b0, mix, {MIX_FRAC{1'b0}}};
         rem_l_ff  <= '0;
         rem_r_ff  <= '0;
         root_l_ff <= '0;
         root_r_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_l_ff  <= {rad_l_ff[RAD_W-3:0], 2'b00};
         rad_r_ff  <= {rad_r_ff[RAD_W-3:0], 2'b00};
         {rem_l_ff, root_l_ff} <= step_l;
         {rem_r_ff, root_r_ff} <= step_r;
      end
   end

   // Shared multiplier operand selection
   always_comb begin
      case (cmd.mul_op)
         MOP_SG: begin
            mul_a = MA_W'(sample_ff);
            mul_b = {1'b0, gain_ff};
         end
         MOP_PAN_L: begin
            mul_a = sg_ff;
            mul_b = {1'b0, root_l_ff};
         end
         default: begin
            mul_a = sg_ff;
            mul_b = {1'b0, root_r_ff};
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // Product registers
   always_ff @(posedge clock) begin
      case (cmd.mul_op) inside
         MOP_SG:                sg_ff   <= product[MA_W-1:0];
         MOP_PAN_L, MOP_PAN_R:  prod_ff <= product;
         default: ;
      endcase
   end

   // Floor shift, then saturating add
   assign term    = prod_ff[PROD_W-1:PROD_SHIFT];
   assign acc_sel = (cmd.acc_op == ACC_LEFT) ? left_acc_ff : right_acc_ff;
   assign sum     = SUM_W'(acc_sel) + SUM_W'(term);
   assign acc_new = sat_acc(sum);

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         left_acc_ff  <= '0;
         right_acc_ff <= '0;
      end else begin
         if (cmd.acc_op == ACC_LEFT)  left_acc_ff  <= acc_new;
         if (cmd.acc_op == ACC_RIGHT) right_acc_ff <= acc_new;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         left_sum_ff  <= sat_out(left_acc_ff);
         right_sum_ff <= sat_out(right_acc_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_sum    = left_sum_ff;
   assign rsp_right_sum   = right_sum_ff;
   assign status.last     = last_ff;
   assign status.out_full = rsp_valid_ff;

endmodule

`default_nettype wire

[test/constant_power_stereo_mixer_top_tb.sv]
// Self-checking testbench for constant_power_stereo_mixer_top: random and directed channel
// frames, a square-root pan law predictor and an in-order scoreboard of stereo sums.
// Depends on cpsm_pkg and the constant_power_stereo_mixer_top RTL.
`default_nettype none

module constant_power_stereo_mixer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpsm_pkg::*;

   localparam int SMP_W       = 16;
   localparam int ACC_W       = 40;
   localparam int STALL_LIMIT = 3000;
   localparam int ITEM_TARGET = 1500;
   localparam int IDLE_PCT    = 36;

   // Predictor and store of expected sums, one entry per frame
   class mix_scoreboard;
      typedef struct {
         logic signed [OUT_W-1:0] left;
         logic signed [OUT_W-1:0] right;
      } stereo_sum_type;

      stereo_sum_type expected_sums[$];
      longint      left_total;
      longint      right_total;
      int          errors;

      function new();
         left_total  = 0;
         right_total = 0;
         errors      = 0;
      endfunction

      // Floor square root, one result bit for each two bits of the radicand per step
      function automatic logic [31:0] floor_root(logic [31:0] x);
         logic [31:0] res;
         logic [31:0] one;
         res = 0;
         one = 32'h4000_0000;
         while (one > x) one = one >> 2;
         while (one != 0) begin
            if (x >= res + one) begin
               x   = x - (res + one);
               res = (res >> 1) + one;
            end else begin
               res = res >> 1;
            end
            one = one >> 2;
         end
         return res;
      endfunction

      function automatic longint sat_acc(longint s);
         longint hi;
         longint lo;
         hi = (64'sd1 <<< (ACC_W - 1)) - 1;
         lo = -hi - 1;
         if (s > hi) return hi;
         if (s < lo) return lo;
         return s;
      endfunction

      function automatic logic signed [OUT_W-1:0] sat_out(longint v);
         if (v > 64'sd8388607) v = 64'sd8388607;
         if (v < -64'sd8388608) v = -64'sd8388608;
         return v[OUT_W-1:0];
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction

      // Accepted channel: add its contribution, close the frame on last
      function void note_channel(logic signed [SMP_W-1:0] smp, logic [GAIN_W-1:0] gain,
                                 logic signed [PAN_W-1:0] pan, logic is_last);
         longint      pan_c;
         logic [31:0] mix;
         logic [31:0] g_left;
         logic [31:0] g_right;
         longint      sg;
         stereo_sum_type sum;
         pan_c = longint'(pan);
         if (pan < PAN_MIN) pan_c = longint'(PAN_MIN);
         if (pan > PAN_MAX) pan_c = longint'(PAN_MAX);
         mix     = 32'(pan_c + 32768);
         g_right = floor_root(mix << MIX_FRAC);
         g_left  = floor_root((32'(MIX_ONE) - mix) << MIX_FRAC);
         sg = longint'(smp) * longint'({1'b0, gain});
         // arithmetic shift of a signed product rounds toward minus infinity
         left_total  = sat_acc(left_total + ((sg * longint'(g_left)) >>> PROD_SHIFT));
         right_total = sat_acc(right_total + ((sg * longint'(g_right)) >>> PROD_SHIFT));
         if (is_last) begin
            sum.left  = sat_out(left_total);
            sum.right = sat_out(right_total);
            expected_sums.push_back(sum);
            left_total  = 0;
            right_total = 0;
         end
      endfunction

      // Accepted result against the oldest expected frame sum
      function void check_sum(logic signed [OUT_W-1:0] left, logic signed [OUT_W-1:0] right);
         stereo_sum_type want;
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected result left=%0d right=%0d", $realtime, left, right);
            errors++;
            return;
         end
         want = expected_sums.pop_front();
         if (left !== want.left) begin
            $display("%0t: left_sum expected %0d actual %0d", $realtime, want.left, left);
            errors++;
         end
         if (right !== want.right) begin
            $display("%0t: right_sum expected %0d actual %0d", $realtime, want.right, right);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SMP_W-1:0]    req_sample = '0;
   logic        [GAIN_W-1:0]   req_channel_gain = '0;
   logic signed [PAN_W-1:0]    req_pan_position = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]    rsp_left_sum;
   logic signed [OUT_W-1:0]    rsp_right_sum;

   mix_scoreboard sb = new();
   bit            idling_on = 1'b1;
   int            stall_cycles = 0;
   int            channels_sent = 0;

   constant_power_stereo_mixer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_channel_gain (req_channel_gain),
      .req_pan_position (req_pan_position),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sum     (rsp_left_sum),
      .rsp_right_sum    (rsp_right_sum)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: check accepted sums, stall at random, count quiet cycles
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
         rsp_ready    <= 1'b0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (rsp_valid && rsp_ready)
            sb.check_sum(rsp_left_sum, rsp_right_sum);
         rsp_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog on handshake progress
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // One channel transaction, with optional random idle cycles ahead of it
   task automatic send_channel(logic signed [SMP_W-1:0] smp, logic [GAIN_W-1:0] gain,
                               logic signed [PAN_W-1:0] pan, logic is_last);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= smp;
      req_channel_gain <= gain;
      req_pan_position <= pan;
      req_last         <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_channel(smp, gain, pan, is_last);
      channels_sent++;
   endtask

   function automatic logic signed [PAN_W-1:0] random_pan();
      int sel;
      sel = $urandom_range(99);
      if (sel < 12) return PAN_W'($urandom);
      if (sel < 17) return PAN_MIN;
      if (sel < 22) return PAN_MAX;
      return PAN_W'(int'($urandom_range(65536)) - 32768);
   endfunction

   // Short frames with random content; now and then a long loud one to hit saturation
   task automatic send_random_frame();
      int  len;
      bit  loud;
      bit  neg;
      logic signed [SMP_W-1:0] smp;
      logic signed [PAN_W-1:0] pan;
      loud = ($urandom_range(19) == 0);
      neg  = ($urandom_range(1) == 1);
      len  = loud ? $urandom_range(80, 60) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
         if (loud) begin
            smp = neg ? 16'sh8000 : 16'sh7fff;
            if ($urandom_range(9) == 0) smp = SMP_W'($urandom);
            pan = ($urandom_range(3) == 0) ? random_pan() :
                  ($urandom_range(1) ? PAN_MIN : PAN_MAX);
            send_channel(smp, GAIN_W'($urandom_range(65535, 49152)), pan, i == len - 1);
         end else begin
            send_channel(SMP_W'($urandom), GAIN_W'($urandom), random_pan(), i == len - 1);
         end
      end
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, centre, clamping, floor of tiny negatives, a multi-channel frame
      send_channel(16'sh7fff, 16'd16384, 17'sd0, 1'b1);
      send_channel(16'sh8000, 16'hffff, 17'sh10000, 1'b1);
      send_channel(16'sh7fff, 16'hffff, 17'sh0ffff, 1'b1);
      send_channel(16'sh8000, 16'hffff, PAN_MIN, 1'b1);
      send_channel(16'sh7fff, 16'hffff, PAN_MAX, 1'b1);
      send_channel(16'sh7fff, 16'hffff, -17'sd32769, 1'b1);
      send_channel(16'sh8000, 16'hffff, 17'sd32769, 1'b1);
      send_channel(-16'sd1, 16'd1, 17'sd0, 1'b1);
      send_channel(16'sd1, 16'd1, 17'sd0, 1'b1);
      send_channel(16'sd0, 16'd0, 17'sd0, 1'b1);
      send_channel(16'sh5555, 16'haaaa, 17'sh0aaaa, 1'b0);
      send_channel(16'shaaaa, 16'h5555, 17'sh15555, 1'b0);
      send_channel(16'sh1234, 16'd16384, -17'sd16384, 1'b1);
      send_channel(16'sh8000, 16'd16384, 17'sd1, 1'b0);
      send_channel(16'sh7fff, 16'd16384, -17'sd1, 1'b1);

      // Random frames; one stretch without random idles and one pause until all sums are back
      while (channels_sent < ITEM_TARGET) begin
         idling_on = !(channels_sent >= 300 && channels_sent < 550);
         if (!paused && channels_sent >= 700) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         send_random_frame();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/cpsm_pkg.sv
src/cpsm_ctrl.sv
src/cpsm_datapath.sv
src/constant_power_stereo_mixer_top.sv
test/constant_power_stereo_mixer_top_tb.sv
